>>> sv/windowed_integral_pid_clamped_top_assert.svh
// Assertion macros for the checker file of the windowed integral PID block.
`ifndef WINDOWED_INTEGRAL_PID_CLAMPED_TOP_ASSERT_SVH
`define WINDOWED_INTEGRAL_PID_CLAMPED_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define WIPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WIPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> sv/wipc_pkg.sv
// Types and constants of the windowed integral PID block.
package wipc_pkg;

	// Field widths fixed by the interface
	localparam int COORD_BITS    = 11;
	localparam int ERR_W         = COORD_BITS + 1;
	localparam int DIFF_W        = COORD_BITS + 2;
	localparam int GAIN_W        = 16;
	localparam int WINDOW_W      = 11;
	localparam int LIMIT_W       = 15;
	localparam int DRIVE_W       = 16;
	localparam int OUT_FRAC_BITS = 8;

	// Configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KI     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KD     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 3'd4;

	// Register reset values
	localparam logic signed [GAIN_W-1:0] KP_RESET     = -16'sd205;
	localparam logic signed [GAIN_W-1:0] KI_RESET     = -16'sd20;
	localparam logic signed [GAIN_W-1:0] KD_RESET     = 16'sd0;
	localparam logic [WINDOW_W-1:0]      WINDOW_RESET = 11'd100;
	localparam logic [LIMIT_W-1:0]       LIMIT_RESET  = 15'd11520;

	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef logic [COORD_BITS-1:0]    coord_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef struct packed {
		coord_t measured_position;
		coord_t target_position;
	} in_word_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive_value;
		logic                      clamped;
	} out_word_t;

endpackage

>>> sv/windowed_integral_pid_clamped_top.sv
// Top level of the windowed integral PID block with clamped output.
// One positional PID axis. Each input word carries a measured and a target coordinate;
// a measured coordinate of zero means no detection, and that word is dropped with no
// result and no state change. The error is measured minus target; the integral sums it
// (saturating to INTEGRAL_BITS) while its magnitude is below the window and is cleared
// otherwise; the derivative is the error minus the previous error. The drive is
// kp*e + ki*I + kd*d with Q.GAIN_FRAC_BITS gains, rounded to Q8.8 and clamped to the
// output limit, with a flag. The block takes one word per cycle while the output side
// can move; each result passes the input register, state update, product register and
// output register in turn, and the whole pipe halts while the output word waits to
// be taken.
// Registers sit on the APB port at byte addresses 0 (kp), 4 (ki), 8 (kd), 12 (window)
// and 16 (limit); write them only while the block is idle.
module windowed_integral_pid_clamped_top
	import wipc_pkg::*;
#(
	parameter int INTEGRAL_BITS  = 24,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int ACC_W  = INTEGRAL_BITS + 1;
	localparam int PW_P   = GAIN_W + ERR_W;
	localparam int PW_I   = GAIN_W + INTEGRAL_BITS;
	localparam int PW_D   = GAIN_W + DIFF_W;
	localparam int PW_MAX = (PW_I > PW_D) ? PW_I : PW_D;
	localparam int SUM_W  = PW_MAX + 3;
	localparam int SH     = GAIN_FRAC_BITS - OUT_FRAC_BITS;

	// Configuration registers
	gain_t                kp_q, ki_q, kd_q;
	logic [WINDOW_W-1:0]  window_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	// Pipeline
	logic                            adv;
	logic                            valid_s1, valid_s2, valid_s3, out_valid_q;
	coord_t                          meas_s1, targ_s1;
	err_t                            prev_err_q, err_s2;
	diff_t                           diff_s2;
	logic signed [INTEGRAL_BITS-1:0] integ_q, integ_s2;
	logic signed [PW_P-1:0]          prod_p_s3;
	logic signed [PW_I-1:0]          prod_i_s3;
	logic signed [PW_D-1:0]          prod_d_s3;
	out_word_t                       out_data_q;

	// Stage 1 combinational
	err_t                            err;
	diff_t                           diff;
	logic [ERR_W-1:0]                mag_full;
	logic [WINDOW_W-1:0]             mag;
	logic signed [ACC_W-1:0]         acc;
	logic signed [INTEGRAL_BITS-1:0] integ_next;

	// Stage 3 combinational
	logic signed [SUM_W-1:0]   sum, q, lim_ext, neg_lim;
	out_word_t                 result;

	assign reg_idx = paddr[REG_IDX_W+1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= KP_RESET;
			ki_q     <= KI_RESET;
			kd_q     <= KD_RESET;
			window_q <= WINDOW_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_KP:     kp_q     <= pwdata[GAIN_W-1:0];
				REG_KI:     ki_q     <= pwdata[GAIN_W-1:0];
				REG_KD:     kd_q     <= pwdata[GAIN_W-1:0];
				REG_WINDOW: window_q <= pwdata[WINDOW_W-1:0];
				REG_LIMIT:  limit_q  <= pwdata[LIMIT_W-1:0];
				default:    ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (reg_idx)
			REG_KP:     prdata = CFG_DATA_W'(kp_q);
			REG_KI:     prdata = CFG_DATA_W'(ki_q);
			REG_KD:     prdata = CFG_DATA_W'(kd_q);
			REG_WINDOW: prdata = CFG_DATA_W'(window_q);
			REG_LIMIT:  prdata = CFG_DATA_W'(limit_q);
			default:    prdata = '0;
		endcase
	end

	// Advance the whole pipe whenever the output register is free or being emptied
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// Stage 1: error, derivative and windowed saturating integral
	always_comb begin
		err      = signed'({1'b0, meas_s1}) - signed'({1'b0, targ_s1});
		diff     = DIFF_W'(err) - DIFF_W'(prev_err_q);
		mag_full = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
		mag      = mag_full[WINDOW_W-1:0];
		acc      = ACC_W'(integ_q) + ACC_W'(err);
		if (mag >= window_q) begin
			integ_next = '0;
		end else if (acc[ACC_W-1] != acc[ACC_W-2]) begin
			integ_next = acc[ACC_W-1] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
			                          : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
		end else begin
			integ_next = acc[INTEGRAL_BITS-1:0];
		end
	end

	// Control: valid bits and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			prev_err_q  <= '0;
			integ_q     <= '0;
		end else if (adv) begin
			// drop words with no detection at the door
			valid_s1    <= in_valid && (in_data.measured_position != '0);
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (valid_s1) begin
				prev_err_q <= err;
				integ_q    <= integ_next;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			meas_s1    <= in_data.measured_position;
			targ_s1    <= in_data.target_position;
			err_s2     <= err;
			diff_s2    <= diff;
			integ_s2   <= integ_next;
			prod_p_s3  <= kp_q * err_s2;
			prod_i_s3  <= ki_q * integ_s2;
			prod_d_s3  <= kd_q * diff_s2;
			out_data_q <= result;
		end
	end

	// Stage 3: sum, round to Q8.8, clamp
	assign sum = SUM_W'(prod_p_s3) + SUM_W'(prod_i_s3) + SUM_W'(prod_d_s3);

	generate
		if (SH > 0) begin : g_round
			localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (SH - 1);
			assign q = (sum + HALF) >>> SH;
		end else begin : g_no_round
			assign q = sum;
		end
	endgenerate

	assign lim_ext = signed'(SUM_W'(limit_q));
	assign neg_lim = -lim_ext;

	always_comb begin
		if (q > lim_ext) begin
			result.drive_value = lim_ext[DRIVE_W-1:0];
			result.clamped     = 1'b1;
		end else if (q < neg_lim) begin
			result.drive_value = neg_lim[DRIVE_W-1:0];
			result.clamped     = 1'b1;
		end else begin
			result.drive_value = q[DRIVE_W-1:0];
			result.clamped     = 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> sv/wipc_checker.sv
// Port-level checks for the windowed integral PID block, bound to its top level.
`include "windowed_integral_pid_clamped_top_assert.svh"

module wipc_checker
	import wipc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data,
	input logic      pready
);

	// A stalled result word holds
	`WIPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

	// The pipe takes a word exactly when the output side can move
	`WIPC_ASSERT_NOW(a_in_ready, clk, arst_n, 1'b1, in_ready == (!out_valid || out_ready), "input ready disagrees with output stall")

	// A clamped drive is never the most negative code, the limit is at most 15 bits
	`WIPC_ASSERT_NOW(a_clamp_range, clk, arst_n, out_valid && out_data.clamped, out_data.drive_value != 16'sh8000, "clamped drive outside limit range")

	// Register port never waits
	`WIPC_ASSERT_NOW(a_pready, clk, arst_n, 1'b1, pready, "pready dropped")

endmodule

bind windowed_integral_pid_clamped_top wipc_checker u_wipc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.pready    (pready)
);

>>> tb/tb_windowed_integral_pid_clamped_top.sv
// Self-checking testbench for the windowed integral PID block: random handshakes, APB setup, PID predictor.
module tb_windowed_integral_pid_clamped_top;
	import wipc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  INTEGRAL_BITS  = 24;
	localparam int  GAIN_FRAC_BITS = 12;
	localparam int  SETTLE_CYCLES  = 8;
	localparam int  CYCLE_LIMIT    = 2000000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// Register copies as last written
	gain_t               cfg_kp = KP_RESET;
	gain_t               cfg_ki = KI_RESET;
	gain_t               cfg_kd = KD_RESET;
	logic [WINDOW_W-1:0] cfg_window = WINDOW_RESET;
	logic [LIMIT_W-1:0]  cfg_limit = LIMIT_RESET;

	// Loop state of the predicted axis
	err_t                            last_error = '0;
	logic signed [INTEGRAL_BITS-1:0] error_sum = '0;

	in_word_t  pending_words[$];
	out_word_t drive_expected[$];
	int        words_queued = 0;
	int        in_accept_cnt = 0;
	int        out_accept_cnt = 0;
	int        mismatches = 0;
	int        cycle_count = 0;

	windowed_integral_pid_clamped_top #(
		.INTEGRAL_BITS (INTEGRAL_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Wait length per word: a random gap, with occasional stretches of none
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	// Mostly modest gains so that the drive stays off the clamp, now and then any value
	function automatic gain_t rand_gain();
		if ($urandom_range(0, 3) == 0)
			return gain_t'($urandom);
		return gain_t'(int'($urandom_range(0, 1024)) - 512);
	endfunction

	// Advance the loop state by one word and work out its drive; no detection gives nothing
	function automatic bit predict_drive(input in_word_t w, output out_word_t r);
		longint err, slope, mag, isum, imax, imin, acc, q, lim;
		int     sh;
		bit     hit;
		r = '0;
		hit = 1'b0;
		if (w.measured_position == '0)
			return 1'b0;
		err = longint'(w.measured_position) - longint'(w.target_position);
		slope = err - longint'(last_error);
		last_error = err_t'(err);
		// accumulate inside the window, saturating; clear outside it
		mag = (err < 0) ? -err : err;
		imax = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
		imin = -imax - 1;
		if (mag < longint'(cfg_window)) begin
			isum = longint'(error_sum) + err;
			if (isum > imax)
				isum = imax;
			if (isum < imin)
				isum = imin;
			error_sum = isum[INTEGRAL_BITS-1:0];
		end else begin
			error_sum = '0;
		end
		acc = longint'(cfg_kp) * err + longint'(cfg_ki) * longint'(error_sum)
			+ longint'(cfg_kd) * slope;
		// round to Q8.8, half up
		sh = GAIN_FRAC_BITS - OUT_FRAC_BITS;
		if (sh > 0)
			q = (acc + (longint'(1) <<< (sh - 1))) >>> sh;
		else
			q = acc;
		lim = longint'(cfg_limit);
		if (q > lim) begin
			q = lim;
			hit = 1'b1;
		end
		if (q < -lim) begin
			q = -lim;
			hit = 1'b1;
		end
		r.drive_value = q[DRIVE_W-1:0];
		r.clamped = hit;
		return 1'b1;
	endfunction

	// Sender: present the next word after its drawn gap, hold it until taken
	int launched = 0;
	int send_gap = 0;
	int send_calm = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_accept_cnt != launched)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_data <= pending_words.pop_front();
				in_valid <= 1'b1;
				launched++;
				send_gap = draw_wait(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall a drawn number of cycles before each result word
	int results_seen = 0;
	int stall_left = 0;
	int recv_calm = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_accept_cnt != results_seen) begin
				results_seen = out_accept_cnt;
				stall_left = draw_wait(recv_calm);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Predict on every accepted input word
	always @(posedge clk) begin
		out_word_t predicted;
		if (arst_n && in_valid && in_ready) begin
			if (predict_drive(in_data, predicted))
				drive_expected.push_back(predicted);
			in_accept_cnt <= in_accept_cnt + 1;
		end
	end

	// Compare every accepted result word with the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (drive_expected.size() == 0) begin
				$error("unexpected result word: drive_value %0d clamped %0b",
					out_data.drive_value, out_data.clamped);
				mismatches++;
			end else begin
				want = drive_expected.pop_front();
				if (out_data.drive_value !== want.drive_value) begin
					$error("drive_value: expected %0d, got %0d",
						want.drive_value, out_data.drive_value);
					mismatches++;
				end
				if (out_data.clamped !== want.clamped) begin
					$error("clamped: expected %0b, got %0b", want.clamped, out_data.clamped);
					mismatches++;
				end
			end
			out_accept_cnt <= out_accept_cnt + 1;
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic queue_word(input coord_t meas, input coord_t targ);
		in_word_t w;
		w.measured_position = meas;
		w.target_position = targ;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// Hold until every word is taken and every result has come, then let the pipe empty
	task automatic drain_pipe();
		while (!(pending_words.size() == 0 && in_accept_cnt == words_queued
				&& drive_expected.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, register taken at the access edge
	task automatic write_register(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_KP:     cfg_kp = value[GAIN_W-1:0];
			REG_KI:     cfg_ki = value[GAIN_W-1:0];
			REG_KD:     cfg_kd = value[GAIN_W-1:0];
			REG_WINDOW: cfg_window = value[WINDOW_W-1:0];
			REG_LIMIT:  cfg_limit = value[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic reconfigure(input gain_t kp, input gain_t ki, input gain_t kd,
			input logic [WINDOW_W-1:0] win, input logic [LIMIT_W-1:0] lim);
		drain_pipe();
		write_register(REG_KP, CFG_DATA_W'(kp));
		write_register(REG_KI, CFG_DATA_W'(ki));
		write_register(REG_KD, CFG_DATA_W'(kd));
		write_register(REG_WINDOW, CFG_DATA_W'(win));
		write_register(REG_LIMIT, CFG_DATA_W'(lim));
	endtask

	initial begin
		coord_t meas, targ;
		int     ph, counted, span, off, t, k;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words at the reset settings: no detection, extremes, window edges
		queue_word(11'd0, 11'd500);
		queue_word(11'd2047, 11'd0);
		queue_word(11'd1, 11'd2047);
		queue_word(11'd1000, 11'd1000);
		queue_word(11'd1050, 11'd1000);
		queue_word(11'd1099, 11'd1000);
		queue_word(11'd0, 11'd0);
		queue_word(11'd1100, 11'd1000);
		queue_word(11'd901, 11'd1000);
		queue_word(11'd902, 11'd1000);
		queue_word(11'd900, 11'd1000);
		queue_word(11'd2047, 11'd2047);
		queue_word(11'd1024, 11'd1023);
		queue_word(11'd0, 11'd2047);
		queue_word(11'd1365, 11'd682);
		queue_word(11'd682, 11'd1365);
		queue_word(11'd1, 11'd1);
		queue_word(11'd1, 11'd0);

		// Random phases: both extreme settings first, then random settings
		for (ph = 0; ph < 7; ph++) begin
			case (ph)
				0: reconfigure(16'sh7FFF, 16'sh8000, 16'sh8000, 11'd0, 15'd0);
				1: reconfigure(16'sh8000, 16'sh7FFF, 16'sh7FFF, 11'h7FF, 15'h7FFF);
				default: reconfigure(rand_gain(), rand_gain(), rand_gain(),
					($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
						: 11'($urandom_range(1, 300)),
					15'($urandom_range(0, 32767)));
			endcase
			counted = 0;
			while (counted < 140) begin
				meas = 11'($urandom_range(1, 2047));
				if ($urandom_range(0, 3) == 0) begin
					targ = 11'($urandom);
				end else begin
					// keep the error near the window so the integral gets to run
					span = int'(cfg_window) + 2;
					off = int'($urandom_range(0, 2 * span)) - span;
					t = int'(meas) - off;
					if (t < 0)
						t = 0;
					if (t > 2047)
						t = 2047;
					targ = 11'(t);
				end
				if ($urandom_range(0, 15) == 0) begin
					queue_word(11'd0, targ);
				end else begin
					queue_word(meas, targ);
					counted++;
				end
			end
		end

		// Run the integral up and down and bring it into view through ki alone
		reconfigure(16'sd0, 16'sd1, 16'sd0, 11'h7FF, 15'h7FFF);
		for (k = 0; k < 20; k++)
			queue_word(11'd2047, 11'd1);
		for (k = 0; k < 20; k++)
			queue_word(11'd1, 11'd2047);
		queue_word(11'd2047, 11'd0);
		for (k = 0; k < 20; k++)
			queue_word(11'($urandom_range(0, 2047)), 11'($urandom));

		drain_pipe();
		if (mismatches == 0 && drive_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/wipc_pkg.sv
sv/windowed_integral_pid_clamped_top.sv
sv/wipc_checker.sv
tb/tb_windowed_integral_pid_clamped_top.sv
